// ----- sv/csl_pkg.sv -----
package csl_pkg;

    // Fixed-point scale of all Q.16 quantities.
    localparam int FRAC_BITS = 16;

    localparam int FIELD_W   = 24;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W    = 44;   // axle_track * |k|
    localparam int DENOM_W   = 28;   // 1 + track*|k|/2, Q.16
    localparam int GRIP_QW   = 48;   // coef * 2^32 / |k|, below 2^48 when not saturated

    localparam logic [FIELD_W-1:0] SPEED_MAX = '1;

    // g = 9.81 m/s^2 rounded to Q.16
    localparam logic [19:0] GRAVITY_Q = 20'd642908;

    localparam logic [1:0] CAUSE_STRAIGHT = 2'd0;
    localparam logic [1:0] CAUSE_MOTOR    = 2'd1;
    localparam logic [1:0] CAUSE_GRIP     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_AXLE_TRACK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRICTION   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COM_LAT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COM_HEIGHT = 2'd3;

    localparam logic [CFG_W-1:0] RST_AXLE_TRACK = 20'd39322;
    localparam logic [15:0]      RST_FRICTION   = 16'd4096;
    localparam logic [CFG_W-1:0] RST_COM_LAT    = 20'd0;
    localparam logic [CFG_W-1:0] RST_COM_HEIGHT = 20'd19661;

endpackage

// ----- sv/csl_div_pipe.sv -----
module csl_div_pipe import csl_pkg::*; #(
    parameter int QW  = 24,
    parameter int DVW = 28,
    parameter int SW  = 24
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  logic [DVW-1:0] i_rem_init,  // must be below i_dvs
    input  logic [QW-1:0]  i_low,       // dividend bits still to bring down, MSB first
    input  logic [DVW-1:0] i_dvs,
    input  logic [SW-1:0]  i_side,
    output logic           o_vld,
    output logic [QW-1:0]  o_quo,
    output logic [SW-1:0]  o_side
);

    logic           r_vld  [QW];
    logic [DVW-1:0] r_rem  [QW];
    logic [DVW-1:0] r_dvs  [QW];
    logic [QW-1:0]  r_qd   [QW];   // unused dividend bits on top, quotient bits below
    logic [SW-1:0]  r_side [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic           p_vld;
        logic [DVW-1:0] p_rem;
        logic [DVW-1:0] p_dvs;
        logic [QW-1:0]  p_qd;
        logic [SW-1:0]  p_side;
        logic [DVW:0]   trial;
        logic [DVW:0]   diff;
        logic           ge;

        if (k == 0) begin : g_first
            assign p_vld  = i_vld;
            assign p_rem  = i_rem_init;
            assign p_dvs  = i_dvs;
            assign p_qd   = i_low;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_dvs  = r_dvs[k-1];
            assign p_qd   = r_qd[k-1];
            assign p_side = r_side[k-1];
        end

        assign trial = {p_rem, p_qd[QW-1]};
        assign diff  = trial - {1'b0, p_dvs};
        assign ge    = trial >= {1'b0, p_dvs};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? diff[DVW-1:0] : trial[DVW-1:0];
                r_dvs[k]  <= p_dvs;
                r_qd[k]   <= {p_qd[QW-2:0], ge};
                r_side[k] <= p_side;
            end
        end
    end

    assign o_vld  = r_vld[QW-1];
    assign o_quo  = r_qd[QW-1];
    assign o_side = r_side[QW-1];

endmodule

// ----- sv/csl_sqrt_pipe.sv -----
module csl_sqrt_pipe import csl_pkg::*; #(
    parameter int RW = 24,
    parameter int SW = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  logic [2*RW-1:0] i_rad,
    input  logic [SW-1:0]   i_side,
    output logic            o_vld,
    output logic [RW-1:0]   o_root,
    output logic [SW-1:0]   o_side
);

    localparam int NW = 2 * RW;

    logic          r_vld  [RW];
    logic [RW:0]   r_rem  [RW];
    logic [RW-1:0] r_root [RW];
    logic [NW-1:0] r_rad  [RW];
    logic [SW-1:0] r_side [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic          p_vld;
        logic [RW:0]   p_rem;
        logic [RW-1:0] p_root;
        logic [NW-1:0] p_rad;
        logic [SW-1:0] p_side;
        logic [RW+2:0] cur;
        logic [RW+2:0] trial;
        logic [RW+2:0] diff;
        logic          ge;

        if (k == 0) begin : g_first
            assign p_vld  = i_vld;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_rad  = i_rad;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_rad  = r_rad[k-1];
            assign p_side = r_side[k-1];
        end

        // bring down two radicand bits, try root*4+1
        assign cur   = {p_rem, p_rad[NW-1:NW-2]};
        assign trial = {1'b0, p_root, 2'b01};
        assign diff  = cur - trial;
        assign ge    = cur >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? diff[RW:0] : cur[RW:0];
                r_root[k] <= {p_root[RW-2:0], ge};
                r_rad[k]  <= {p_rad[NW-3:0], 2'b00};
                r_side[k] <= p_side;
            end
        end
    end

    assign o_vld  = r_vld[RW-1];
    assign o_root = r_root[RW-1];
    assign o_side = r_side[RW-1];

endmodule

// ----- sv/csl_coef.sv -----
module csl_coef import csl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [CFG_W-1:0]   i_axle_track,
    input  logic [15:0]        i_friction,
    input  logic [CFG_W-1:0]   i_com_lat,
    input  logic [CFG_W-1:0]   i_com_height,
    output logic [FIELD_W-1:0] o_left_coef,
    output logic [FIELD_W-1:0] o_right_coef,
    output logic               o_busy
);

    localparam int MW  = 21;             // |2*y -/+ t|
    localparam int DW  = MW + FRAC_BITS; // dividend / quotient bits
    localparam int CNW = $clog2(DW);

    typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_DIV, ST_MUL} t_state;

    t_state               r_state;
    logic [CNW-1:0]       r_cnt;
    logic [MW-1:0]        r_dvs;
    logic [MW-1:0]        r_rem_l, r_rem_r;
    logic [DW-1:0]        r_qd_l,  r_qd_r;
    logic [FIELD_W-1:0]   r_left,  r_right;

    logic signed [MW:0]   y2, tt, off_l, off_r;
    logic [MW:0]          mag_l, mag_r;
    logic [MW:0]          trial_l, trial_r, diff_l, diff_r;
    logic                 ge_l, ge_r;
    logic [19:0]          mu_f, m_l, m_r;
    logic [39:0]          prod_l, prod_r;

    always_comb begin
        y2      = {i_com_lat[CFG_W-1], i_com_lat, 1'b0};
        tt      = {2'b00, i_axle_track};
        off_l   = y2 - tt;
        off_r   = y2 + tt;
        mag_l   = off_l[MW] ? -off_l : off_l;
        mag_r   = off_r[MW] ? -off_r : off_r;

        trial_l = {r_rem_l, r_qd_l[DW-1]};
        trial_r = {r_rem_r, r_qd_r[DW-1]};
        diff_l  = trial_l - {1'b0, r_dvs};
        diff_r  = trial_r - {1'b0, r_dvs};
        ge_l    = trial_l >= {1'b0, r_dvs};
        ge_r    = trial_r >= {1'b0, r_dvs};

        // friction widened from Q.12 to Q.16; tipping ratio wins only if smaller
        mu_f    = {i_friction, 4'b0000};
        m_l     = (i_com_height != '0 && r_qd_l < DW'(mu_f)) ? r_qd_l[19:0] : mu_f;
        m_r     = (i_com_height != '0 && r_qd_r < DW'(mu_f)) ? r_qd_r[19:0] : mu_f;
        prod_l  = m_l * GRAVITY_Q;
        prod_r  = m_r * GRAVITY_Q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
        end else if (i_start) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                end
                ST_LOAD: begin
                    r_dvs   <= {i_com_height, 1'b0};
                    r_rem_l <= '0;
                    r_rem_r <= '0;
                    r_qd_l  <= {mag_l[MW-1:0], {FRAC_BITS{1'b0}}};
                    r_qd_r  <= {mag_r[MW-1:0], {FRAC_BITS{1'b0}}};
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_rem_l <= ge_l ? diff_l[MW-1:0] : trial_l[MW-1:0];
                    r_rem_r <= ge_r ? diff_r[MW-1:0] : trial_r[MW-1:0];
                    r_qd_l  <= {r_qd_l[DW-2:0], ge_l};
                    r_qd_r  <= {r_qd_r[DW-2:0], ge_r};
                    r_cnt   <= r_cnt + 1'b1;
                    if (r_cnt == CNW'(DW - 1)) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_left  <= prod_l[FRAC_BITS +: FIELD_W];
                    r_right <= prod_r[FRAC_BITS +: FIELD_W];
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    assign o_left_coef  = r_left;
    assign o_right_coef = r_right;
    assign o_busy       = (r_state != ST_IDLE);

endmodule

// ----- sv/curve_speed_limiter.sv -----
// Curve speed limiter: safe speed of a differential-drive base on a curve.
// Input words (s_axis) carry a signed Q7.16 curvature and a Q8.16 cruise
// velocity; output words (m_axis) carry the Q8.16 speed limit and the
// limiting cause (straight, motor, grip/tip).
// Pipeline: 3 front stages (|k| and coef select, track*|k| product,
// denominator), 48 stages of a bit-per-stage divider for coef*2^32/|k|,
// then 24 stages in which the square root and the motor divide run side by
// side, and the output register: 76 registers, the first loaded at the
// accepting edge. Throughput is one word per cycle unless the output
// stalls or the coefficient unit is busy; the pipeline's depth is set by
// the grip divide and the square root, one quotient or root bit per stage.
// Config writes (i_cfg_*) update the registers at once and restart the
// turn coefficient unit: a load step, a bit-serial divide and a multiply,
// during which s_axis_tready is low. The same pass runs after reset.
// Reset (synchronous, active low) clears all valid bits and loads the
// default geometry. When m_axis_tready is low with a word held, the whole
// pipeline freezes and s_axis_tready falls in the same cycle.
module curve_speed_limiter import csl_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [47:0]          s_axis_tdata,   // [23:0] curvature, [47:24] cruise_velocity
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata,   // [23:0] speed_limit, [25:24] limit_cause
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int SIDE_W = 2 + FIELD_W + DENOM_W;

    // ---- configuration registers ----
    logic [CFG_W-1:0]   r_axle_track, r_com_lat, r_com_height;
    logic [15:0]        r_friction;
    logic [FIELD_W-1:0] left_coef, right_coef;
    logic               coef_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axle_track <= RST_AXLE_TRACK;
            r_friction   <= RST_FRICTION;
            r_com_lat    <= RST_COM_LAT;
            r_com_height <= RST_COM_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_AXLE_TRACK: r_axle_track <= i_cfg_data;
                REG_FRICTION:   r_friction   <= i_cfg_data[15:0];
                REG_COM_LAT:    r_com_lat    <= i_cfg_data;
                REG_COM_HEIGHT: r_com_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    csl_coef u_coef (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_cfg_we),
        .i_axle_track (r_axle_track),
        .i_friction   (r_friction),
        .i_com_lat    (r_com_lat),
        .i_com_height (r_com_height),
        .o_left_coef  (left_coef),
        .o_right_coef (right_coef),
        .o_busy       (coef_busy)
    );

    // ---- global pipeline advance: frozen while a result waits ----
    logic r_out_vld;
    logic en;

    assign en            = !r_out_vld || m_axis_tready;
    assign s_axis_tready = en && !coef_busy;

    // ---- stage 0: magnitude of curvature, coefficient select ----
    logic [FIELD_W-1:0] k_in, abs_k;
    logic               r_s0_vld, r_s1_vld, r_s2_vld;
    logic [FIELD_W-1:0] r_s0_a, r_s0_coef, r_s0_cruise;
    logic               r_s0_zero;

    assign k_in  = s_axis_tdata[23:0];
    assign abs_k = k_in[FIELD_W-1] ? -k_in : k_in;   // -2^23 stays 2^23 unsigned

    // ---- stage 1: track*|k| and grip saturation check ----
    logic [PROD_W-1:0]  r_s1_prod;
    logic [FIELD_W-1:0] r_s1_a, r_s1_coef, r_s1_cruise;
    logic               r_s1_zero, r_s1_ovf;

    // ---- stage 2: motor denominator ----
    logic [DENOM_W-1:0] r_s2_denom;
    logic [FIELD_W-1:0] r_s2_a, r_s2_coef, r_s2_cruise;
    logic               r_s2_zero, r_s2_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else if (en) begin
            r_s0_vld <= s_axis_tvalid && !coef_busy;
            r_s1_vld <= r_s0_vld;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_a      <= abs_k;
            r_s0_coef   <= k_in[FIELD_W-1] ? right_coef : left_coef;
            r_s0_cruise <= s_axis_tdata[47:24];
            r_s0_zero   <= (k_in == '0);

            r_s1_prod   <= r_axle_track * r_s0_a;
            // coef*2^32/|k| reaches 2^48 exactly when coef >= |k|*2^16
            r_s1_ovf    <= {16'b0, r_s0_coef} >= {r_s0_a, 16'b0};
            r_s1_a      <= r_s0_a;
            r_s1_coef   <= r_s0_coef;
            r_s1_cruise <= r_s0_cruise;
            r_s1_zero   <= r_s0_zero;

            r_s2_denom  <= DENOM_W'(1 << FRAC_BITS)
                         + DENOM_W'(r_s1_prod[PROD_W-1:FRAC_BITS+1]);
            r_s2_ovf    <= r_s1_ovf;
            r_s2_a      <= r_s1_a;
            r_s2_coef   <= r_s1_coef;
            r_s2_cruise <= r_s1_cruise;
            r_s2_zero   <= r_s1_zero;
        end
    end

    // ---- grip divide: coef * 2^32 / |k| ----
    // The top 8 quotient bits are zero when not saturated, so the divide
    // starts with coef[23:16] as partial remainder.
    logic               gd_vld;
    logic [GRIP_QW-1:0] gd_quo;
    logic [SIDE_W-1:0]  gd_side;

    csl_div_pipe #(
        .QW  (GRIP_QW),
        .DVW (FIELD_W),
        .SW  (SIDE_W)
    ) u_grip_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_vld      (r_s2_vld),
        .i_rem_init ({16'b0, r_s2_coef[23:16]}),
        .i_low      ({r_s2_coef[15:0], 32'b0}),
        .i_dvs      (r_s2_a),
        .i_side     ({r_s2_zero, r_s2_ovf, r_s2_cruise, r_s2_denom}),
        .o_vld      (gd_vld),
        .o_quo      (gd_quo),
        .o_side     (gd_side)
    );

    logic               gd_zero, gd_ovf;
    logic [FIELD_W-1:0] gd_cruise;
    logic [DENOM_W-1:0] gd_denom;

    assign {gd_zero, gd_ovf, gd_cruise, gd_denom} = gd_side;

    // ---- square root and motor divide side by side ----
    logic               sq_vld, md_vld;
    logic [FIELD_W-1:0] sq_root, md_quo, md_cruise;
    logic [1:0]         sq_side;

    csl_sqrt_pipe #(
        .RW (FIELD_W),
        .SW (2)
    ) u_grip_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (gd_vld),
        .i_rad   (gd_quo),
        .i_side  ({gd_zero, gd_ovf}),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // cruise*2^16 / denom; denom >= 2^16 keeps the quotient below 2^24
    csl_div_pipe #(
        .QW  (FIELD_W),
        .DVW (DENOM_W),
        .SW  (FIELD_W)
    ) u_motor_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_vld      (gd_vld),
        .i_rem_init ({12'b0, gd_cruise[23:8]}),
        .i_low      ({gd_cruise[7:0], 16'b0}),
        .i_dvs      (gd_denom),
        .i_side     (gd_cruise),
        .o_vld      (md_vld),
        .o_quo      (md_quo),
        .o_side     (md_cruise)
    );

    // ---- output register ----
    logic [FIELD_W-1:0] grip;
    logic [FIELD_W-1:0] r_speed;
    logic [1:0]         r_cause;

    assign grip = sq_side[0] ? SPEED_MAX : sq_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= sq_vld && md_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (sq_side[1]) begin
                r_speed <= md_cruise;
                r_cause <= CAUSE_STRAIGHT;
            end else if (md_quo <= grip) begin
                r_speed <= md_quo;          // tie goes to the motor limit
                r_cause <= CAUSE_MOTOR;
            end else begin
                r_speed <= grip;
                r_cause <= CAUSE_GRIP;
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {6'b0, r_cause, r_speed};

endmodule

// ----- bench/csl_checker.sv -----
module csl_checker import csl_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [47:0]          s_axis_tdata,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [31:0]          m_axis_tdata,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_errors,
    output int                   o_pending
);

    typedef struct packed {
        logic [1:0]         cause;
        logic [FIELD_W-1:0] speed;
    } t_limit;

    t_limit limit_q[$];

    logic [19:0] track, lat, height;
    logic [15:0] mu;
    logic [63:0] coef_left, coef_right;

    function automatic logic [63:0] turn_coef(input logic signed [63:0] off2);
        logic [63:0] m, mag, ratio, prod;
        m = ({48'd0, mu} << FRAC_BITS) >> 12;
        if (height != 0) begin
            mag = off2 < 0 ? -off2 : off2;
            ratio = (mag << FRAC_BITS) / ({44'd0, height} * 2);
            if (ratio < m) m = ratio;
        end
        prod = (m * {44'd0, GRAVITY_Q}) >> FRAC_BITS;
        return prod > 64'hFFFFFF ? 64'hFFFFFF : prod;
    endfunction

    task automatic refresh_coefs();
        logic signed [63:0] y, t;
        y = {{44{lat[19]}}, lat};
        t = {44'd0, track};
        coef_left  = turn_coef(2 * y - t);
        coef_right = turn_coef(2 * y + t);
    endtask

    function automatic logic [63:0] isqrt(input logic [63:0] n);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic t_limit predict_limit(input logic [47:0] w);
        logic [23:0] k;
        logic [63:0] a, coef, denom, motor, q1, rem, n, grip, cruise;
        t_limit r;
        k = w[23:0];
        cruise = {40'd0, w[47:24]};
        if (k == 0) begin
            r.speed = w[47:24];
            r.cause = CAUSE_STRAIGHT;
            return r;
        end
        a = k[23] ? 64'h1000000 - {40'd0, k} : {40'd0, k};
        coef = k[23] ? coef_right : coef_left;
        denom = (64'd1 << FRAC_BITS) + (({44'd0, track} * a) >> (FRAC_BITS + 1));
        motor = (cruise << FRAC_BITS) / denom;
        q1 = (coef << FRAC_BITS) / a;
        rem = (coef << FRAC_BITS) % a;
        if (q1 >= (64'd1 << (48 - FRAC_BITS))) begin
            grip = 64'hFFFFFF;
        end else begin
            n = (q1 << FRAC_BITS) + ((rem << FRAC_BITS) / a);
            grip = isqrt(n);
            if (grip > 64'hFFFFFF) grip = 64'hFFFFFF;
        end
        if (motor <= grip) begin
            r.speed = motor > 64'hFFFFFF ? SPEED_MAX : motor[23:0];
            r.cause = CAUSE_MOTOR;
        end else begin
            r.speed = grip[23:0];
            r.cause = CAUSE_GRIP;
        end
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("mismatch: %s got %0h expected %0h", what, got, want);
        o_errors++;
    endtask

    assign o_pending = limit_q.size();

    always @(posedge i_clk) begin
        t_limit want;
        if (!i_rst_n) begin
            track  = RST_AXLE_TRACK;
            mu     = RST_FRICTION;
            lat    = RST_COM_LAT;
            height = RST_COM_HEIGHT;
            refresh_coefs();
            limit_q.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_AXLE_TRACK: track  = i_cfg_data;
                    REG_FRICTION:   mu     = i_cfg_data[15:0];
                    REG_COM_LAT:    lat    = i_cfg_data;
                    REG_COM_HEIGHT: height = i_cfg_data;
                    default: ;
                endcase
                refresh_coefs();
            end
            if (s_axis_tvalid && s_axis_tready)
                limit_q.push_back(predict_limit(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                if (limit_q.size() == 0) begin
                    report("unexpected word", m_axis_tdata, 32'd0);
                end else begin
                    want = limit_q.pop_front();
                    if (m_axis_tdata[23:0] !== want.speed)
                        report("speed_limit", {8'd0, m_axis_tdata[23:0]},
                               {8'd0, want.speed});
                    if (m_axis_tdata[25:24] !== want.cause)
                        report("limit_cause", {30'd0, m_axis_tdata[25:24]},
                               {30'd0, want.cause});
                end
            end
        end
    end

endmodule

// ----- bench/tb_curve_speed_limiter.sv -----
module tb_curve_speed_limiter;
    import csl_pkg::*;

    localparam int IDLE_LIMIT = 20000;   // cycles with no word moved
    localparam int DRAIN      = 150;     // margin for the full pipeline and a coefficient pass

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 s_axis_tvalid = 0;
    logic                 s_axis_tready;
    logic [47:0]          s_axis_tdata = '0;   // [23:0] curvature, [47:24] cruise_velocity
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 0;
    logic [31:0]          m_axis_tdata;        // [23:0] speed_limit, [25:24] limit_cause
    logic                 i_cfg_we = 0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    int errors, pending;
    int send_idle_pct, recv_stall_pct;
    int quiet_cycles;

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    curve_speed_limiter u_dut (.*);

    csl_checker u_chk (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_errors(errors), .o_pending(pending)
    );

    // receiver back-pressure
    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // watchdog: restarts whenever a word moves on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb_curve_speed_limiter failed");
            $finish;
        end
    end

    // one word, with random sender gaps before it; tvalid stays high after
    // the accept until the next gap or drain drops it
    task automatic send_word(input logic [23:0] k, input logic [23:0] v);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {v, k};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    // block is drained before any register write; the caller drops i_cfg_we
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
        i_cfg_we   <= 1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
    endtask

    // mostly small/moderate curvature, occasional full-range values
    function automatic logic [23:0] rand_curvature();
        logic [23:0] k;
        case ($urandom_range(5))
            0:       k = 24'($urandom);
            1:       k = 24'd0;
            2:       k = 24'($urandom_range(4));
            3:       k = 24'(-$urandom_range(1 << 16));
            default: k = 24'($urandom_range(1 << 18) - (1 << 17));
        endcase
        return k;
    endfunction

    task automatic random_burst(input int n, input int idle, input int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        repeat (n) send_word(rand_curvature(), 24'($urandom));
    endtask

    initial begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: straight, extremes, both turn directions, tiny |k|
        send_word(24'd0, 24'hFFFFFF);
        send_word(24'd0, 24'd0);
        send_word(24'h7FFFFF, 24'hFFFFFF);
        send_word(24'h800000, 24'hFFFFFF);   // most negative curvature
        send_word(24'd1, 24'hFFFFFF);        // grip saturates
        send_word(24'hFFFFFF, 24'hFFFFFF);
        send_word(24'd65536, 24'd65536);
        send_word(-24'sd65536, 24'd65536);
        send_word(24'd32768, 24'd0);
        send_word(24'd655360, 24'd1 << 20);
        send_word(-24'sd655360, 24'd1 << 20);
        send_word(24'h555555, 24'hAAAAAA);
        send_word(24'hAAAAAA, 24'h555555);
        drain();   // sender holds off until all results are back

        // no idling, reset geometry
        random_burst(100, 0, 0);
        drain();

        // asymmetric CoM, max friction, zero height; includes ignored-free extremes
        write_reg(REG_AXLE_TRACK, 20'hFFFFF);
        write_reg(REG_FRICTION, 20'hFFFF);
        write_reg(REG_COM_LAT, 20'h7FFFF);
        write_reg(REG_COM_HEIGHT, 20'd0);
        i_cfg_we <= 0;
        random_burst(120, 85, 0);
        drain();

        write_reg(REG_AXLE_TRACK, 20'd0);
        write_reg(REG_FRICTION, 20'd0);
        write_reg(REG_COM_LAT, 20'h80000);
        write_reg(REG_COM_HEIGHT, 20'hFFFFF);
        i_cfg_we <= 0;
        random_burst(120, 0, 85);
        drain();

        write_reg(REG_AXLE_TRACK, 20'd45000);
        write_reg(REG_FRICTION, 20'd6000);
        write_reg(REG_COM_LAT, -20'sd3000);
        write_reg(REG_COM_HEIGHT, 20'd1);
        i_cfg_we <= 0;
        random_burst(130, 6, 6);
        drain();

        // random settings
        write_reg(REG_AXLE_TRACK, 20'($urandom));
        write_reg(REG_FRICTION, 20'($urandom));
        write_reg(REG_COM_LAT, 20'($urandom));
        write_reg(REG_COM_HEIGHT, 20'($urandom));
        i_cfg_we <= 0;
        random_burst(130, 30, 30);
        drain();

        if (errors == 0)
            $display("tb_curve_speed_limiter passed");
        else
            $display("tb_curve_speed_limiter failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/csl_pkg.sv
sv/csl_div_pipe.sv
sv/csl_sqrt_pipe.sv
sv/csl_coef.sv
sv/curve_speed_limiter.sv
bench/csl_checker.sv
bench/tb_curve_speed_limiter.sv
